>>> rtl/mahf_pkg.sv
package mahf_pkg;

  localparam int unsigned WINDOW    = 50;
  localparam int unsigned SLOT_W    = $clog2(WINDOW);
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned TEMP_W    = 19;

  // sum / WINDOW as (sum * RECIP) >> DIV_SHIFT; exact for every 16-bit sum
  // while (RECIP * WINDOW - 2**DIV_SHIFT) * 65535 < 2**DIV_SHIFT.
  localparam int unsigned DIV_SHIFT = 22;
  localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  localparam logic [8:0]        SCALE     = 9'd500;
  localparam logic [TEMP_W-1:0] THR_RESET = 19'd819;

  typedef struct packed {
    logic take;    // item accepted: read oldest slot
    logic commit;  // item leaves window stage: write slot, update sum
  } win_ctl_t;

endpackage

>>> rtl/mahf_window.sv
module mahf_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mahf_pkg::win_ctl_t              ctl,
  input  logic [mahf_pkg::SAMPLE_W-1:0]   sample,
  output logic [mahf_pkg::SUM_W-1:0]      sum_nxt
);

  logic [mahf_pkg::SAMPLE_W-1:0] store [mahf_pkg::WINDOW];
  logic [mahf_pkg::WINDOW-1:0]   vld_r;
  logic [mahf_pkg::SLOT_W-1:0]   slot_r;
  logic [mahf_pkg::SLOT_W-1:0]   slot_nxt;
  logic [mahf_pkg::SLOT_W-1:0]   wslot_r;
  logic [mahf_pkg::SAMPLE_W-1:0] smp_r;
  logic [mahf_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                          rd_vld_r;
  logic [mahf_pkg::SUM_W-1:0]    sum_r;
  logic [mahf_pkg::SAMPLE_W-1:0] old_smp;

  assign slot_nxt = (slot_r == mahf_pkg::SLOT_W'(mahf_pkg::WINDOW - 1)) ?
                    '0 : slot_r + 1'b1;

  // Sample store: one read at accept, one write at commit. The slot read
  // is always the one after the slot being written, so no bypass.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      store[wslot_r] <= smp_r;
    end
    if (ctl.take) begin
      rd_data_r <= store[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      rd_vld_r <= vld_r[slot_r];
      smp_r    <= sample;
      wslot_r  <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      vld_r  <= '0;
      sum_r  <= '0;
    end else begin
      if (ctl.take) begin
        slot_r <= slot_nxt;
      end
      if (ctl.commit) begin
        vld_r[wslot_r] <= 1'b1;
        sum_r          <= sum_nxt;
      end
    end
  end

  // never-written slot counts as zero
  assign old_smp = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - mahf_pkg::SUM_W'(old_smp) + mahf_pkg::SUM_W'(smp_r);

endmodule

>>> rtl/moving_average_hysteresis_filter.sv
// Moving-average temperature filter with a hysteresis-held shown value.
//
// Input channel (in_valid/in_ready/in_sample): one 10-bit converter sample
// per item. Output channel (out_valid/out_ready/out_*): one result item per
// input item, in order: the truncated window mean, that mean times 500
// (temperature in 1/1024 degree), the held (shown) temperature, and a flag
// set when this item replaced the held value.
// Config: cfg_wr_en/cfg_wr_data write the 19-bit hysteresis threshold at
// the clock edge; write it only while no item is in flight.
//
// Throughput: one item per cycle while the receiver keeps up. A result
// passes the window read at the accepting edge, then the sum,
// divide-by-multiply, scale and compare/output registers. The pace is
// set by the update of the running sum and held temperature, each a
// feedback register.
// Reset (rst_n low, synchronous): window slots are marked empty (read as
// zero), sum, slot pointer and held temperature clear, threshold = 819.
// Receiver stall: each stage advances only into an empty or draining
// stage, so bubbles collapse and up to four more items are taken while a
// result waits; in_ready drops only when all stages are full.
module moving_average_hysteresis_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mahf_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mahf_pkg::SAMPLE_W-1:0]   out_average,
  output logic [mahf_pkg::TEMP_W-1:0]     out_temperature_now,
  output logic                            out_shown_changed,
  output logic [mahf_pkg::TEMP_W-1:0]     out_shown_temperature,
  input  logic                            cfg_wr_en,
  input  logic [mahf_pkg::TEMP_W-1:0]     cfg_wr_data
);

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic en1, en2, en3, en4, eno;

  mahf_pkg::win_ctl_t            win_ctl;
  logic [mahf_pkg::SUM_W-1:0]    sum_nxt;

  logic [mahf_pkg::SUM_W-1:0]    sum2_r;
  logic [mahf_pkg::PROD_W-1:0]   quot_prod;
  logic [mahf_pkg::SAMPLE_W-1:0] avg3_r;
  logic [mahf_pkg::SAMPLE_W-1:0] avg4_r;
  logic [mahf_pkg::TEMP_W-1:0]   temp4_r;

  logic [mahf_pkg::TEMP_W-1:0]   thr_r;
  logic [mahf_pkg::TEMP_W-1:0]   held_r;
  logic [mahf_pkg::TEMP_W-1:0]   held_nxt;
  logic                          chg_nxt;
  logic [mahf_pkg::TEMP_W:0]     upper;
  logic [mahf_pkg::TEMP_W:0]     lower;

  logic [mahf_pkg::SAMPLE_W-1:0] avg_o_r;
  logic [mahf_pkg::TEMP_W-1:0]   temp_o_r;
  logic                          chg_o_r;
  logic [mahf_pkg::TEMP_W-1:0]   shown_o_r;

  // Stage enables: a stage loads when its holder is empty or moving on.
  assign eno      = !vo_r || out_ready;
  assign en4      = !v4_r || eno;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign win_ctl.take   = in_valid && en1;
  assign win_ctl.commit = v1_r && en2;

  // Stage 1: ring store and running sum.
  mahf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .sample  (in_sample),
    .sum_nxt (sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      vo_r   <= 1'b0;
      thr_r  <= mahf_pkg::THR_RESET;
      held_r <= '0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (eno) vo_r <= v4_r;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (v4_r && eno) begin
        held_r <= held_nxt;
      end
    end
  end

  // Stage 2 -> 3: sum / WINDOW via reciprocal multiply.
  assign quot_prod = mahf_pkg::PROD_W'(sum2_r) *
                     mahf_pkg::PROD_W'(mahf_pkg::RECIP);

  // Compare at one extra bit so neither band edge wraps.
  assign upper = {1'b0, held_r} + {1'b0, thr_r};
  assign lower = {1'b0, temp4_r} + {1'b0, thr_r};

  always_comb begin
    chg_nxt  = ({1'b0, temp4_r} > upper) || (lower < {1'b0, held_r});
    held_nxt = chg_nxt ? temp4_r : held_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum2_r <= sum_nxt;
    end
    if (en3) begin
      avg3_r <= quot_prod[mahf_pkg::DIV_SHIFT +: mahf_pkg::SAMPLE_W];
    end
    if (en4) begin
      avg4_r  <= avg3_r;
      temp4_r <= mahf_pkg::TEMP_W'(avg3_r) * mahf_pkg::TEMP_W'(mahf_pkg::SCALE);
    end
    if (eno) begin
      avg_o_r   <= avg4_r;
      temp_o_r  <= temp4_r;
      chg_o_r   <= chg_nxt;
      shown_o_r <= held_nxt;
    end
  end

  assign out_valid             = vo_r;
  assign out_average           = avg_o_r;
  assign out_temperature_now   = temp_o_r;
  assign out_shown_changed     = chg_o_r;
  assign out_shown_temperature = shown_o_r;

  // in_ready only drops when the output holds an unaccepted result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (held_r == out_shown_temperature))
    else $error("held temperature diverges from shown output");

  a_chg_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_shown_changed) |-> (out_shown_temperature == out_temperature_now))
    else $error("changed flag without taking new temperature");

  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_now ==
                   mahf_pkg::TEMP_W'(out_average) * mahf_pkg::TEMP_W'(mahf_pkg::SCALE)))
    else $error("temperature not average times scale");

endmodule

>>> test/tb.sv
module tb;

  // Worst case is roughly 900 items under heavy stalls;
  // this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Wait past the pipeline depth so a stray result shows up.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int          SAMPLE_MAX   = (1 << mahf_pkg::SAMPLE_W) - 1;
  localparam logic [mahf_pkg::SAMPLE_W-1:0] SAMPLE_TOP = '1;

  typedef struct packed {
    logic [mahf_pkg::SAMPLE_W-1:0] average;
    logic [mahf_pkg::TEMP_W-1:0]   temperature_now;
    logic                          shown_changed;
    logic [mahf_pkg::TEMP_W-1:0]   shown_temperature;
  } reading_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [mahf_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mahf_pkg::SAMPLE_W-1:0] out_average;
  logic [mahf_pkg::TEMP_W-1:0]   out_temperature_now;
  logic                          out_shown_changed;
  logic [mahf_pkg::TEMP_W-1:0]   out_shown_temperature;
  logic                          cfg_wr_en = 1'b0;
  logic [mahf_pkg::TEMP_W-1:0]   cfg_wr_data = '0;

  moving_average_hysteresis_filter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sample             (in_sample),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_average           (out_average),
    .out_temperature_now   (out_temperature_now),
    .out_shown_changed     (out_shown_changed),
    .out_shown_temperature (out_shown_temperature),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Filter state mirrored on the testbench side. It is advanced once per
  // accepted item.
  logic [mahf_pkg::SAMPLE_W-1:0] window_samples [mahf_pkg::WINDOW];
  logic [mahf_pkg::SLOT_W-1:0]   write_slot;
  logic [mahf_pkg::SUM_W-1:0]    running_sum;
  logic [mahf_pkg::TEMP_W-1:0]   held_temp;
  logic [mahf_pkg::TEMP_W-1:0]   band_limit;

  logic [mahf_pkg::SAMPLE_W-1:0] pending_samples [$];
  reading_t                      expected_readings [$];
  reading_t                      oldest_reading;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned shown_updates = 0;
  int unsigned band_settings = 1;
  int unsigned failures = 0;
  int unsigned reported = 0;

  // One item through the filter: ring update, running sum, truncated mean,
  // scaling, then the hysteresis decision on the shown value.
  function automatic reading_t advance_filter(
      input logic [mahf_pkg::SAMPLE_W-1:0] sample);
    reading_t    r;
    int unsigned now_t;
    int unsigned held_t;
    int unsigned band_t;
    running_sum = running_sum - mahf_pkg::SUM_W'(window_samples[write_slot]) +
                  mahf_pkg::SUM_W'(sample);
    window_samples[write_slot] = sample;
    write_slot = (write_slot == mahf_pkg::SLOT_W'(mahf_pkg::WINDOW - 1)) ?
                 '0 : write_slot + 1'b1;
    r.average = mahf_pkg::SAMPLE_W'(running_sum / mahf_pkg::WINDOW);
    r.temperature_now = mahf_pkg::TEMP_W'(r.average) *
                        mahf_pkg::TEMP_W'(mahf_pkg::SCALE);
    now_t  = 32'(r.temperature_now);
    held_t = 32'(held_temp);
    band_t = 32'(band_limit);
    // Full-width compares: the lower band may reach below zero, and that
    // must not wrap.
    r.shown_changed = (now_t > held_t + band_t) || (now_t + band_t < held_t);
    if (r.shown_changed)
      held_temp = r.temperature_now;
    r.shown_temperature = held_temp;
    return r;
  endfunction

  function automatic logic [mahf_pkg::SAMPLE_W-1:0] clip_sample(input int v);
    if (v < 0)
      return '0;
    if (v > SAMPLE_MAX)
      return SAMPLE_TOP;
    return mahf_pkg::SAMPLE_W'(v);
  endfunction

  // Sensor-like traces: noisy plateaus, ramps, rail bursts and some white
  // noise. Plateaus let the mean settle, so the band compare is exercised
  // around its edges.
  task automatic queue_samples(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned shape;
    int          base;
    int          span;
    int          slope;
    left = count;
    while (left > 0) begin
      shape = $urandom_range(9);
      run = $urandom_range(60, 5);
      if (run > left)
        run = left;
      base = $urandom_range(SAMPLE_MAX);
      if (shape <= 5) begin
        span = $urandom_range(40);
        repeat (run)
          pending_samples.push_back(clip_sample(base + $urandom_range(2 * span) - span));
      end else if (shape <= 7) begin
        slope = $urandom_range(60) - 30;
        for (int i = 0; i < run; i++)
          pending_samples.push_back(clip_sample(base + i * slope));
      end else if (shape == 8) begin
        repeat (run)
          pending_samples.push_back(mahf_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX)));
      end else begin
        repeat (run)
          pending_samples.push_back($urandom_range(1) ? SAMPLE_TOP : '0);
      end
      left -= run;
    end
  endtask

  // Wait until no sample is pending, in flight or unanswered. Sampled on
  // the falling edge, so every update of the step has settled.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  // The register loads at the edge where the enable is high.
  task automatic write_band(input logic [mahf_pkg::TEMP_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    band_limit = value;
    band_settings++;
  endtask

  // Sample driver. Valid holds until the item is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(advance_filter(in_sample));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Results come back in order, so each one is checked
  // against the oldest open expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          failures++;
          if (reported < REPORT_MAX) begin
            $display("cycle %0d: result with nothing expected: avg=%0d temp=%0d chg=%0b shown=%0d",
                     cycle_count, out_average, out_temperature_now, out_shown_changed,
                     out_shown_temperature);
            reported++;
          end
        end else begin
          oldest_reading = expected_readings.pop_front();
          readings_checked++;
          if (oldest_reading.shown_changed)
            shown_updates++;
          if (out_average !== oldest_reading.average ||
              out_temperature_now !== oldest_reading.temperature_now ||
              out_shown_changed !== oldest_reading.shown_changed ||
              out_shown_temperature !== oldest_reading.shown_temperature) begin
            failures++;
            if (reported < REPORT_MAX) begin
              $display("cycle %0d: expected avg=%0d temp=%0d chg=%0b shown=%0d",
                       cycle_count, oldest_reading.average, oldest_reading.temperature_now,
                       oldest_reading.shown_changed, oldest_reading.shown_temperature);
              $display("            got      avg=%0d temp=%0d chg=%0b shown=%0d",
                       out_average, out_temperature_now, out_shown_changed,
                       out_shown_temperature);
              reported++;
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d readings still open", cycle_count,
               expected_readings.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    foreach (window_samples[i])
      window_samples[i] = '0;
    write_slot  = '0;
    running_sum = '0;
    held_temp   = '0;
    band_limit  = mahf_pkg::THR_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: the sender idles a little and the receiver idles often.
    send_idle_pct = 13;
    recv_idle_pct = 53;

    // Directed part at the reset band.
    // A zero first sample leaves temp at 0 with held 0. The lower band then
    // sits below zero, so nothing may trigger.
    pending_samples.push_back('0);
    // A full-scale run lifts the mean from its empty-window start, and the
    // shown value steps up.
    repeat (12)
      pending_samples.push_back(SAMPLE_TOP);
    // Alternating bit patterns.
    pending_samples.push_back(10'h155);
    pending_samples.push_back(10'h2AA);
    // Zeros and small values drag the mean back down and can trip the
    // lower band.
    repeat (3)
      pending_samples.push_back('0);
    pending_samples.push_back(mahf_pkg::SAMPLE_W'(1));
    pending_samples.push_back(SAMPLE_TOP);
    pending_samples.push_back(mahf_pkg::SAMPLE_W'(512));
    pending_samples.push_back(SAMPLE_TOP);
    pending_samples.push_back('0);
    wait_idle();

    // Zero band: any change of the mean moves the shown value.
    write_band('0);
    queue_samples(200);
    // The sender holds off until everything is answered, then resumes
    // without a register write.
    wait_idle();
    queue_samples(80);
    wait_idle();

    // Band wider than the whole range: the shown value freezes.
    write_band({mahf_pkg::TEMP_W{1'b1}});
    queue_samples(100);
    wait_idle();

    // Phase two: heavy sender gaps, light receiver stalls.
    send_idle_pct = 53;
    recv_idle_pct = 13;
    // The band equals one step of the mean. The compare is strict, so a
    // single-step move must hold.
    write_band(mahf_pkg::TEMP_W'(mahf_pkg::SCALE));
    queue_samples(200);
    wait_idle();
    write_band(19'h2AAAA);
    queue_samples(60);
    wait_idle();

    // Phase three: no idling on either side, the pipeline runs full.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_band(mahf_pkg::TEMP_W'($urandom_range(3000, 1)));
    queue_samples(200);
    wait_idle();
    write_band(mahf_pkg::THR_RESET);
    queue_samples(40);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d readings checked, %0d shown-value updates",
             samples_sent, readings_checked, shown_updates);
    $display("%0d band settings under three handshake mixes, %0d failures",
             band_settings, failures);
    if (failures == 0 && expected_readings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
